>>> hw/rtl/key_ring_partition_lookup_defines.svh
// ---------------------------------------------------------------------------
// Key ring partition lookup: assertion macros
// Shared concurrent assertion forms for the lookup block.
// ---------------------------------------------------------------------------
`ifndef KEY_RING_PARTITION_LOOKUP_DEFINES_SVH
`define KEY_RING_PARTITION_LOOKUP_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define KRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("key ring lookup: assertion failed");
// Next-cycle implication
`define KRP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("key ring lookup: assertion failed");
`else
`define KRP_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define KRP_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

>>> hw/rtl/krp_pkg.sv
// ---------------------------------------------------------------------------
// Key ring partition lookup package
// Operation and status codes, controller states, command and status groups.
// ---------------------------------------------------------------------------
`default_nettype none

package krp_pkg;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_ADD    = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_QUERY  = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_ABSENT = 2'd1,
		ST_FULL   = 2'd2,
		ST_DUP    = 2'd3
	} status_t;

	// Key memory read address source
	typedef enum logic [2:0] {
		RD_NONE,
		RD_SCAN,
		RD_LAST,
		RD_FIRST,
		RD_SECOND,
		RD_AHEAD,
		RD_MOVE
	} rd_sel_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_ADD_DECIDE,
		S_MOVE_RD,
		S_MOVE_WR,
		S_INSERT,
		S_PRIME_LAST,
		S_PRIME_FIRST,
		S_PRIME_SECOND,
		S_PRIME_FILL,
		S_SPAN,
		S_BOUND,
		S_CHECK,
		S_FINISH
	} ctrl_state_t;

	typedef struct packed {
		logic    latch;
		rd_sel_t rd_sel;
		logic    id_walk;
		logic    scan_init;
		logic    scan_cmp;
		logic    move_wr;
		logic    insert;
		logic    clear_cnt;
		logic    win_shift;
		logic    span;
		logic    bound;
		logic    walk_next;
		logic    res_load;
		status_t res_status;
		logic    res_take;
	} ctrl_cmd_t;

	typedef struct packed {
		op_t  op;
		logic cnt_zero;
		logic full;
		logic dup;
		logic move_done;
		logic walk_last;
		logic hit;
		logic out_busy;
	} dp_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/krp_ctrl.sv
// ---------------------------------------------------------------------------
// Key ring partition lookup controller
// Sequences scan, shift, insert and ring walk steps over the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

module krp_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  krp_pkg::dp_status_t   st,
	output krp_pkg::ctrl_cmd_t    cmd
);
	import krp_pkg::*;

	ctrl_state_t state_q, state_d;
	status_t     fin_status_q, fin_status_d;
	logic        fin_take_q, fin_take_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			fin_status_q <= ST_OK;
			fin_take_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			fin_status_q <= fin_status_d;
			fin_take_q   <= fin_take_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		fin_status_d = fin_status_q;
		fin_take_d   = fin_take_q;
		cmd          = '0;
		cmd.rd_sel   = RD_NONE;
		cmd.res_status = ST_OK;
		in_ready     = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				cmd.scan_init = 1'b1;
				fin_status_d  = ST_OK;
				fin_take_d    = 1'b0;
				case (st.op)
					OP_CLEAR: begin
						cmd.clear_cnt = 1'b1;
						state_d       = S_FINISH;
					end
					OP_ADD: begin
						state_d = st.cnt_zero ? S_ADD_DECIDE : S_SCAN_RD;
					end
					default: begin
						if (st.cnt_zero) begin
							fin_status_d = ST_ABSENT;
							state_d      = S_FINISH;
						end else begin
							state_d = S_PRIME_LAST;
						end
					end
				endcase
			end
			S_SCAN_RD: begin
				cmd.rd_sel = RD_SCAN;
				state_d    = S_SCAN_CMP;
			end
			S_SCAN_CMP: begin
				cmd.scan_cmp = 1'b1;
				state_d      = st.walk_last ? S_ADD_DECIDE : S_SCAN_RD;
			end
			S_ADD_DECIDE: begin
				if (st.dup) begin
					fin_status_d = ST_DUP;
					state_d      = S_FINISH;
				end else if (st.full) begin
					fin_status_d = ST_FULL;
					state_d      = S_FINISH;
				end else if (st.move_done) begin
					state_d = S_INSERT;
				end else begin
					state_d = S_MOVE_RD;
				end
			end
			S_MOVE_RD: begin
				cmd.rd_sel = RD_MOVE;
				state_d    = S_MOVE_WR;
			end
			S_MOVE_WR: begin
				cmd.move_wr = 1'b1;
				state_d     = S_ADD_DECIDE;
			end
			S_INSERT: begin
				cmd.insert = 1'b1;
				state_d    = S_FINISH;
			end
			S_PRIME_LAST: begin
				cmd.rd_sel = RD_LAST;
				state_d    = S_PRIME_FIRST;
			end
			S_PRIME_FIRST: begin
				cmd.rd_sel    = RD_FIRST;
				cmd.win_shift = 1'b1;
				state_d       = S_PRIME_SECOND;
			end
			S_PRIME_SECOND: begin
				cmd.rd_sel    = RD_SECOND;
				cmd.win_shift = 1'b1;
				state_d       = S_PRIME_FILL;
			end
			S_PRIME_FILL: begin
				cmd.win_shift = 1'b1;
				state_d       = S_SPAN;
			end
			S_SPAN: begin
				cmd.span    = 1'b1;
				cmd.rd_sel  = RD_AHEAD;
				cmd.id_walk = 1'b1;
				state_d     = S_BOUND;
			end
			S_BOUND: begin
				cmd.bound = 1'b1;
				state_d   = S_CHECK;
			end
			S_CHECK: begin
				if (st.hit) begin
					fin_take_d = 1'b1;
					state_d    = S_FINISH;
				end else if (st.walk_last) begin
					fin_status_d = (st.op == OP_QUERY) ? ST_ABSENT : ST_OK;
					state_d      = S_FINISH;
				end else begin
					cmd.win_shift = 1'b1;
					cmd.walk_next = 1'b1;
					state_d       = S_SPAN;
				end
			end
			S_FINISH: begin
				// hold until the output register is free
				if (!st.out_busy) begin
					cmd.res_load   = 1'b1;
					cmd.res_status = fin_status_q;
					cmd.res_take   = fin_take_q;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> hw/rtl/krp_datapath.sv
// ---------------------------------------------------------------------------
// Key ring partition lookup datapath
// Node memories, scan counters, ring window, range unit and result register.
// ---------------------------------------------------------------------------
`default_nettype none

module krp_datapath #(
	parameter int KEY_WIDTH = 32,
	parameter int MAX_NODES = 16,
	parameter int ID_WIDTH  = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic [1:0]     in_op,
	input  wire logic [15:0]    in_id,
	input  wire logic [31:0]    in_key,
	input  krp_pkg::ctrl_cmd_t  cmd,
	output krp_pkg::dp_status_t st,
	output logic                out_valid,
	input  wire logic           out_ready,
	output logic [1:0]          out_status,
	output logic [15:0]         out_owner,
	output logic [31:0]         out_low,
	output logic [31:0]         out_high
);
	import krp_pkg::*;

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int CNT_W = $clog2(MAX_NODES + 1);

	logic [KEY_WIDTH-1:0] key_mem [MAX_NODES];
	logic [ID_WIDTH-1:0]  id_mem  [MAX_NODES];

	op_t                  op_q;
	logic [ID_WIDTH-1:0]  id_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     ahead_q;
	logic [CNT_W-1:0]     pos_q;
	logic [CNT_W-1:0]     j_q;
	logic                 dup_q;
	logic [KEY_WIDTH-1:0] key_rd_q;
	logic [ID_WIDTH-1:0]  id_rd_q;
	logic [KEY_WIDTH-1:0] prev_q, cur_q, next_q;
	logic [KEY_WIDTH-1:0] below_q, above_q;
	logic [KEY_WIDTH-1:0] lo_q, hi_q;
	logic                 out_valid_q;

	logic [63:0]          key_in_ext;
	logic [31:0]          id_in_ext;
	logic [KEY_WIDTH+31:0] lo_ext, hi_ext;
	logic [ID_WIDTH+15:0] owner_ext;
	logic [CNT_W-1:0]     cnt_m1, move_src_full;
	logic [IDX_W-1:0]     last_idx, second_idx, move_src;
	logic [IDX_W-1:0]     key_raddr, id_raddr, waddr;
	logic                 key_ren, id_ren, mem_we;
	logic [KEY_WIDTH-1:0] wkey;
	logic [ID_WIDTH-1:0]  wid;
	logic [KEY_WIDTH-1:0] off_k, off_b;
	logic                 in_range;

	function automatic logic [IDX_W-1:0] inc_wrap(input logic [IDX_W-1:0] a,
		input logic [CNT_W-1:0] n);
		logic [CNT_W-1:0] a1;
		begin
			a1 = CNT_W'(a) + CNT_W'(1);
			inc_wrap = (a1 == n) ? '0 : a1[IDX_W-1:0];
		end
	endfunction

	assign key_in_ext    = {32'b0, in_key};
	assign id_in_ext     = {16'b0, in_id};
	assign cnt_m1        = cnt_q - CNT_W'(1);
	assign last_idx      = cnt_m1[IDX_W-1:0];
	assign second_idx    = inc_wrap('0, cnt_q);
	assign move_src_full = j_q - CNT_W'(1);
	assign move_src      = move_src_full[IDX_W-1:0];

	always_comb begin
		case (cmd.rd_sel)
			RD_SCAN:   key_raddr = idx_q;
			RD_LAST:   key_raddr = last_idx;
			RD_FIRST:  key_raddr = '0;
			RD_SECOND: key_raddr = second_idx;
			RD_AHEAD:  key_raddr = ahead_q;
			RD_MOVE:   key_raddr = move_src;
			default:   key_raddr = '0;
		endcase
	end

	assign key_ren  = (cmd.rd_sel != RD_NONE);
	assign id_ren   = cmd.id_walk || (cmd.rd_sel == RD_MOVE);
	assign id_raddr = cmd.id_walk ? idx_q : move_src;
	assign mem_we   = cmd.move_wr || cmd.insert;
	assign waddr    = cmd.move_wr ? j_q[IDX_W-1:0] : pos_q[IDX_W-1:0];
	assign wkey     = cmd.move_wr ? key_rd_q : key_q;
	assign wid      = cmd.move_wr ? id_rd_q : id_q;

	// node memories: one write port, one registered read port each
	always_ff @(posedge clk) begin
		if (mem_we) begin
			key_mem[waddr] <= wkey;
			id_mem[waddr]  <= wid;
		end
		if (key_ren) begin
			key_rd_q <= key_mem[key_raddr];
		end
		if (id_ren) begin
			id_rd_q <= id_mem[id_raddr];
		end
	end

	// control counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			idx_q   <= '0;
			ahead_q <= '0;
			pos_q   <= '0;
			j_q     <= '0;
			dup_q   <= 1'b0;
		end else begin
			if (cmd.clear_cnt) begin
				cnt_q <= '0;
			end else if (cmd.insert) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (cmd.scan_init) begin
				idx_q <= '0;
				pos_q <= '0;
				dup_q <= 1'b0;
				j_q   <= cnt_q;
			end else begin
				if (cmd.scan_cmp || cmd.walk_next) begin
					idx_q <= idx_q + IDX_W'(1);
				end
				if (cmd.scan_cmp) begin
					if (key_rd_q == key_q) begin
						dup_q <= 1'b1;
					end else if (key_rd_q < key_q) begin
						pos_q <= CNT_W'(idx_q) + CNT_W'(1);
					end
				end
				if (cmd.move_wr) begin
					j_q <= move_src_full;
				end
			end
			if (cmd.rd_sel == RD_SECOND) begin
				ahead_q <= inc_wrap(second_idx, cnt_q);
			end else if (cmd.rd_sel == RD_AHEAD) begin
				ahead_q <= inc_wrap(ahead_q, cnt_q);
			end
		end
	end

	// item latch, ring window and range unit
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q  <= op_t'(in_op);
			id_q  <= id_in_ext[ID_WIDTH-1:0];
			key_q <= key_in_ext[KEY_WIDTH-1:0];
		end
		if (cmd.win_shift) begin
			prev_q <= cur_q;
			cur_q  <= next_q;
			next_q <= key_rd_q;
		end
		if (cmd.span) begin
			below_q <= cur_q - prev_q;
			above_q <= next_q - cur_q;
		end
		if (cmd.bound) begin
			if (cnt_q == CNT_W'(1)) begin
				lo_q <= '0;
				hi_q <= '1;
			end else begin
				lo_q <= cur_q - (below_q >> 1);
				// an even gap gives its midpoint to the successor
				hi_q <= cur_q + (above_q >> 1) - {{(KEY_WIDTH-1){1'b0}}, ~above_q[0]};
			end
		end
	end

	assign off_k    = key_q - lo_q;
	assign off_b    = hi_q - lo_q;
	assign in_range = (off_k <= off_b);

	assign lo_ext    = {32'b0, lo_q};
	assign hi_ext    = {32'b0, hi_q};
	assign owner_ext = {16'b0, id_rd_q};

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_status <= cmd.res_status;
			out_owner  <= cmd.res_take ? owner_ext[15:0] : '0;
			out_low    <= cmd.res_take ? lo_ext[31:0] : '0;
			out_high   <= cmd.res_take ? hi_ext[31:0] : '0;
		end
	end

	assign out_valid = out_valid_q;

	assign st.op        = op_q;
	assign st.cnt_zero  = (cnt_q == '0);
	assign st.full      = (cnt_q == CNT_W'(MAX_NODES));
	assign st.dup       = dup_q;
	assign st.move_done = (j_q == pos_q);
	assign st.walk_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
	assign st.hit       = (op_q == OP_QUERY) ? (id_rd_q == id_q) : in_range;
	assign st.out_busy  = out_valid_q && !out_ready;

endmodule

`default_nettype wire

>>> hw/rtl/key_ring_partition_lookup.sv
// ---------------------------------------------------------------------------
// Key ring partition lookup
// Sorted table of up to MAX_NODES nodes on a ring of 2^KEY_WIDTH keys; each
// node owns the keys from the midpoint after its predecessor up to just
// before the midpoint toward its successor.
// Input stream s_axis: one word per operation, tuser carries the operation
// (clear, add node, lookup key, query node range), tdata the node id and key.
// Output stream m_axis: exactly one word per input word, in order; tuser
// carries the status, tdata the owner id and the inclusive range.
// An add scans every entry, then moves each larger entry up one place and
// inserts; a refused add moves nothing. A lookup or query walks the ring
// from the first node until one matches or the last is passed; a clear, or a
// lookup or query on an empty table, goes straight to its result.
// One word is in work at a time; the next is accepted only once the result
// of the last is loaded. The result waits in an output register; a stalled
// receiver holds the block only when a second result is ready and the first
// has not been taken.
// Reset empties the table at once (entry count to zero) and drops any
// pending result; the node memories are not cleared.
// ---------------------------------------------------------------------------
`default_nettype none

`include "key_ring_partition_lookup_defines.svh"

module key_ring_partition_lookup #(
	parameter int KEY_WIDTH = 32,
	parameter int MAX_NODES = 16,
	parameter int ID_WIDTH  = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [47:0] s_axis_tdata,  // [15:0] node_id, [47:16] key
	input  wire logic [1:0]  s_axis_tuser,  // [1:0] operation
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [79:0]      m_axis_tdata,  // [15:0] owner_id, [47:16] range_low,
	                                        // [79:48] range_high
	output logic [1:0]       m_axis_tuser   // [1:0] status
);
	import krp_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t dp_st;

	// sequencing of every operation
	krp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.st       (dp_st),
		.cmd      (cmd)
	);

	// node storage, ring window and result register
	krp_datapath #(
		.KEY_WIDTH (KEY_WIDTH),
		.MAX_NODES (MAX_NODES),
		.ID_WIDTH  (ID_WIDTH)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_op      (s_axis_tuser),
		.in_id      (s_axis_tdata[15:0]),
		.in_key     (s_axis_tdata[47:16]),
		.cmd        (cmd),
		.st         (dp_st),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_status (m_axis_tuser),
		.out_owner  (m_axis_tdata[15:0]),
		.out_low    (m_axis_tdata[47:16]),
		.out_high   (m_axis_tdata[79:48])
	);

	// an accepted word keeps the input closed on the next cycle
	`KRP_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	// never overwrite a result that the receiver has not taken
	`KRP_ASSERT_IMPLY(a_no_overwrite, clk, arst_n, cmd.res_load, !dp_st.out_busy)
	// a loaded result is offered on the next cycle
	`KRP_ASSERT_NEXT(a_result_offered, clk, arst_n, cmd.res_load, m_axis_tvalid)

endmodule

`default_nettype wire
